[rtl/core/rmt_pkg.sv]
`default_nettype none

package rmt_pkg;

  localparam int VAL_W     = 32;
  localparam int POS_OUT_W = 10;
  localparam int RANGE_W   = 11;

  localparam logic signed [VAL_W-1:0] SENTINEL  = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_CLAMP = 32'sh7fff_fffe;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_LEAF,
    ST_W_COMB,
    ST_Q_WALK,
    ST_Q_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/core/range_min_tree_with_index_core.sv]
`default_nettype none

// Minimum tree over LEAVES leaves (power of two) held in one node memory with one
// read and one write port. After reset a clearing pass writes every node, with busy_o
// high. An item is taken when start_i is high and busy_o low. A write does one leaf
// write, then for each level reads the sibling and writes the parent, and returns to
// idle, where the next transfer is taken. A query walks up the levels and reads at
// most one node from the memory per step, so a level that adds two nodes takes an
// extra step; it then folds in the last node, sees that the walk is over, shows the
// result and returns to idle. The result of a query shows on done_o for exactly one
// cycle and cannot be stalled; writes give no result.

module range_min_tree_with_index_core import rmt_pkg::*; #(
  parameter int LEAVES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        cmd_i,
  input  logic [9:0]                  position_i,
  input  logic signed [VAL_W-1:0]     value_i,
  input  logic [RANGE_W-1:0]          range_lo_i,
  input  logic [RANGE_W-1:0]          range_hi_i,
  output logic                        done_o,
  output logic signed [VAL_W-1:0]     min_value_o,
  output logic [POS_OUT_W-1:0]        min_position_o,
  output logic                        found_o
);

  localparam int LVL = $clog2(LEAVES);
  localparam int PW  = LVL;
  localparam int NW  = LVL + 1;
  localparam int BW  = LVL + 2;
  localparam int DW  = VAL_W + PW + 1;

  state_e state_q, state_d;

  logic [NW-1:0]           n_q, n_d;
  logic [BW-1:0]           l_q, l_d, r_q, r_d;
  logic signed [VAL_W-1:0] acc_val_q, acc_val_d;
  logic [PW-1:0]           acc_pos_q, acc_pos_d;
  logic                    acc_ok_q, acc_ok_d;
  logic                    pend_q, pend_d;

  logic                    ram_we;
  logic [NW-1:0]           ram_waddr, ram_raddr;
  logic [DW-1:0]           ram_wdata, ram_rdata;

  logic signed [VAL_W-1:0] rd_val, sel_val, val_clamped;
  logic [PW-1:0]           rd_pos, sel_pos;
  logic                    rd_ok, sel_ok;

  logic                    pos_ok;
  logic [NW-1:0]           leaf_node, parent;
  logic [BW-1:0]           lo_sat, hi_sat, r_m1, l_p1;

  assign {rd_ok, rd_pos, rd_val} = ram_rdata;

  rmt_node_ram #(
    .ADDR_W (NW),
    .DATA_W (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rmt_min_sel #(
    .POS_W (PW)
  ) u_sel (
    .a_val_i (acc_val_q),
    .a_pos_i (acc_pos_q),
    .a_ok_i  (acc_ok_q),
    .b_val_i (rd_val),
    .b_pos_i (rd_pos),
    .b_ok_i  (rd_ok),
    .val_o   (sel_val),
    .pos_o   (sel_pos),
    .ok_o    (sel_ok)
  );

  assign pos_ok      = 32'(position_i) < 32'(LEAVES);
  assign leaf_node   = NW'(LEAVES) + NW'(position_i);
  assign val_clamped = (value_i == SENTINEL) ? VAL_CLAMP : value_i;
  assign lo_sat      = (32'(range_lo_i) > 32'(LEAVES)) ? BW'(LEAVES) : BW'(range_lo_i);
  assign hi_sat      = (32'(range_hi_i) > 32'(LEAVES)) ? BW'(LEAVES) : BW'(range_hi_i);
  assign parent      = n_q >> 1;
  assign r_m1        = r_q - BW'(1);
  assign l_p1        = l_q + BW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (&n_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          if (cmd_e'(cmd_i) == CMD_QUERY) state_d = ST_Q_WALK;
          else if (pos_ok) state_d = ST_W_LEAF;
        end
      end
      ST_W_LEAF: state_d = ST_W_COMB;
      ST_W_COMB: begin
        if (parent == NW'(1)) state_d = ST_IDLE;
      end
      ST_Q_WALK: begin
        if (!(l_q < r_q) && !pend_q) state_d = ST_Q_DONE;
      end
      ST_Q_DONE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = n_q;
    ram_wdata = {acc_ok_q, acc_pos_q, acc_val_q};
    ram_raddr = n_q ^ NW'(1);
    n_d       = n_q;
    l_d       = l_q;
    r_d       = r_q;
    acc_val_d = acc_val_q;
    acc_pos_d = acc_pos_q;
    acc_ok_d  = acc_ok_q;
    pend_d    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, PW'(0), SENTINEL};
        n_d       = n_q + NW'(1);
      end
      ST_IDLE: begin
        if (start_i) begin
          l_d = lo_sat + BW'(LEAVES);
          r_d = hi_sat + BW'(LEAVES);
          n_d = leaf_node;
          if (cmd_e'(cmd_i) == CMD_QUERY) begin
            acc_val_d = SENTINEL;
            acc_pos_d = '0;
            acc_ok_d  = 1'b0;
          end else begin
            acc_val_d = val_clamped;
            acc_pos_d = PW'(position_i);
            acc_ok_d  = 1'b1;
          end
        end
      end
      ST_W_LEAF: begin
        ram_we = 1'b1;
      end
      ST_W_COMB: begin
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = {sel_ok, sel_pos, sel_val};
        ram_raddr = parent ^ NW'(1);
        acc_val_d = sel_val;
        acc_pos_d = sel_pos;
        acc_ok_d  = sel_ok;
        n_d       = parent;
      end
      ST_Q_WALK: begin
        if (pend_q) begin
          acc_val_d = sel_val;
          acc_pos_d = sel_pos;
          acc_ok_d  = sel_ok;
        end
        if (l_q < r_q) begin
          if (l_q[0]) begin
            ram_raddr = l_q[NW-1:0];
            pend_d    = 1'b1;
            if (r_q[0]) begin
              l_d = l_p1;
            end else begin
              l_d = l_p1 >> 1;
              r_d = r_q >> 1;
            end
          end else if (r_q[0]) begin
            ram_raddr = r_m1[NW-1:0];
            pend_d    = 1'b1;
            l_d       = l_q >> 1;
            r_d       = r_q >> 1;
          end else begin
            l_d = l_q >> 1;
            r_d = r_q >> 1;
          end
        end
      end
      ST_Q_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      n_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q       <= l_d;
    r_q       <= r_d;
    acc_val_q <= acc_val_d;
    acc_pos_q <= acc_pos_d;
    acc_ok_q  <= acc_ok_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = (state_q == ST_Q_DONE);
  assign found_o        = acc_ok_q;
  assign min_value_o    = acc_ok_q ? acc_val_q : SENTINEL;
  assign min_position_o = acc_ok_q ? POS_OUT_W'(acc_pos_q) : '0;

endmodule

`default_nettype wire

[rtl/core/rmt_node_ram.sv]
`default_nettype none

module rmt_node_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 43
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/rmt_min_sel.sv]
`default_nettype none

module rmt_min_sel import rmt_pkg::*; #(
  parameter int POS_W = 10
) (
  input  logic signed [VAL_W-1:0] a_val_i,
  input  logic [POS_W-1:0]        a_pos_i,
  input  logic                    a_ok_i,
  input  logic signed [VAL_W-1:0] b_val_i,
  input  logic [POS_W-1:0]        b_pos_i,
  input  logic                    b_ok_i,
  output logic signed [VAL_W-1:0] val_o,
  output logic [POS_W-1:0]        pos_o,
  output logic                    ok_o
);

  logic a_wins;

  // smaller value wins, on a tie the rightmost position
  assign a_wins = (a_val_i < b_val_i) || ((a_val_i == b_val_i) && (a_pos_i > b_pos_i));

  assign val_o = a_wins ? a_val_i : b_val_i;
  assign pos_o = a_wins ? a_pos_i : b_pos_i;
  assign ok_o  = a_wins ? a_ok_i  : b_ok_i;

endmodule

`default_nettype wire

[rtl/core/rmt_checker.sv]
`default_nettype none

module rmt_checker import rmt_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic                    cmd_i,
  input logic                    done_o,
  input logic signed [VAL_W-1:0] min_value_o,
  input logic [POS_OUT_W-1:0]    min_position_o,
  input logic                    found_o
);

  // a result transfer only happens while the block is busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result outside busy window");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held longer than one cycle");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_e'(cmd_i) == CMD_WRITE)) |=> !done_o)
    else $error("write produced a result");

  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (min_value_o == SENTINEL && min_position_o == '0))
    else $error("empty result not cleared");

  a_found_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (min_value_o != SENTINEL))
    else $error("found result holds sentinel");

endmodule

bind range_min_tree_with_index_core rmt_checker u_rmt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .cmd_i          (cmd_i),
  .done_o         (done_o),
  .min_value_o    (min_value_o),
  .min_position_o (min_position_o),
  .found_o        (found_o)
);

`default_nettype wire

[verif/range_min_tree_with_index_core_test.sv]
`timescale 1ns / 100ps

module range_min_tree_with_index_core_test;
  import rmt_pkg::*;

  localparam int LEAVES = 1024;
  localparam int RANDOM_OPS = 1700;

  typedef struct {
    cmd_e                     cmd;
    logic [9:0]               position;
    logic signed [VAL_W-1:0]  value;
    logic [RANGE_W-1:0]       range_lo;
    logic [RANGE_W-1:0]       range_hi;
    int unsigned              gap;
  } tree_op_t;

  typedef struct {
    logic signed [VAL_W-1:0]  min_value;
    logic [POS_OUT_W-1:0]     min_position;
    logic                     found;
  } range_min_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic                       cmd_i = 1'b0;
  logic [9:0]                 position_i = '0;
  logic signed [VAL_W-1:0]    value_i = '0;
  logic [RANGE_W-1:0]         range_lo_i = '0;
  logic [RANGE_W-1:0]         range_hi_i = '0;
  logic                       busy_o;
  logic                       done_o;
  logic signed [VAL_W-1:0]    min_value_o;
  logic [POS_OUT_W-1:0]       min_position_o;
  logic                       found_o;

  tree_op_t                   pending_ops[$];
  range_min_t                 expected_minima[$];
  logic signed [VAL_W-1:0]    leaf_value[LEAVES];
  bit                         leaf_written[LEAVES];

  tree_op_t                   cur_op;
  range_min_t                 got_min;
  range_min_t                 want_min;
  bit                         took = 1'b0;
  int unsigned                hold_cycles = 0;
  int                         errors = 0;
  int                         n_writes = 0;
  int                         n_queries = 0;
  int                         n_found = 0;
  int                         n_not_found = 0;

  range_min_tree_with_index_core #(
    .LEAVES(LEAVES)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .range_lo_i     (range_lo_i),
    .range_hi_i     (range_hi_i),
    .done_o         (done_o),
    .min_value_o    (min_value_o),
    .min_position_o (min_position_o),
    .found_o        (found_o)
  );

  always #5 clk_i = ~clk_i;

  // minimum over [lo,hi) of written leaves, rightmost position on ties
  function automatic range_min_t predict_range_min(logic [RANGE_W-1:0] lo_in,
                                                   logic [RANGE_W-1:0] hi_in);
    range_min_t res;
    int lo;
    int hi;
    lo = (lo_in > LEAVES) ? LEAVES : int'(lo_in);
    hi = (hi_in > LEAVES) ? LEAVES : int'(hi_in);
    res.min_value = SENTINEL;
    res.min_position = '0;
    res.found = 1'b0;
    for (int i = lo; i < hi; i++) begin
      if (leaf_written[i] && (!res.found || leaf_value[i] <= res.min_value)) begin
        res.min_value = leaf_value[i];
        res.min_position = POS_OUT_W'(i);
        res.found = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic add_write(int unsigned pos, logic signed [VAL_W-1:0] val, int unsigned gap);
    tree_op_t op;
    op.cmd = CMD_WRITE;
    op.position = pos[9:0];
    op.value = val;
    op.range_lo = RANGE_W'($urandom);
    op.range_hi = RANGE_W'($urandom);
    op.gap = gap;
    pending_ops = {pending_ops, op};
  endtask

  task automatic add_query(int unsigned lo, int unsigned hi, int unsigned gap);
    tree_op_t op;
    op.cmd = CMD_QUERY;
    op.position = 10'($urandom);
    op.value = $urandom;
    op.range_lo = lo[RANGE_W-1:0];
    op.range_hi = hi[RANGE_W-1:0];
    op.gap = gap;
    pending_ops = {pending_ops, op};
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || took)) begin
      if (pending_ops.size() == 0) begin
        start_i <= 1'b0;
      end else if (hold_cycles < pending_ops[0].gap) begin
        start_i <= 1'b0;
        hold_cycles++;
      end else begin
        cur_op = pending_ops.pop_front();
        cmd_i <= cur_op.cmd;
        position_i <= cur_op.position;
        value_i <= cur_op.value;
        range_lo_i <= cur_op.range_lo;
        range_hi_i <= cur_op.range_hi;
        start_i <= 1'b1;
        hold_cycles = 0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        got_min.min_value = min_value_o;
        got_min.min_position = min_position_o;
        got_min.found = found_o;
        if (got_min.found) n_found++;
        else n_not_found++;
        if (expected_minima.size() == 0) begin
          $display("%0t: unexpected result value=%0d position=%0d found=%0b", $time,
                   got_min.min_value, got_min.min_position, got_min.found);
          errors++;
        end else begin
          want_min = expected_minima.pop_front();
          if (got_min.min_value !== want_min.min_value) begin
            $display("%0t: min_value expected %0d actual %0d", $time,
                     want_min.min_value, got_min.min_value);
            errors++;
          end
          if (got_min.min_position !== want_min.min_position) begin
            $display("%0t: min_position expected %0d actual %0d", $time,
                     want_min.min_position, got_min.min_position);
            errors++;
          end
          if (got_min.found !== want_min.found) begin
            $display("%0t: found expected %0b actual %0b", $time,
                     want_min.found, got_min.found);
            errors++;
          end
        end
      end
      took = start_i && !busy_o;
      if (took) begin
        if (cmd_i == CMD_WRITE) begin
          // sentinel is clamped so written leaves always beat unwritten ones
          leaf_value[position_i] = (value_i == SENTINEL) ? VAL_CLAMP : value_i;
          leaf_written[position_i] = 1'b1;
          n_writes++;
        end else begin
          expected_minima = {expected_minima, predict_range_min(range_lo_i, range_hi_i)};
          n_queries++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_minima.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned pos;
    int unsigned lo;
    int unsigned hi;
    int unsigned gap;
    logic signed [VAL_W-1:0] val;

    for (int i = 0; i < LEAVES; i++) begin
      leaf_value[i] = SENTINEL;
      leaf_written[i] = 1'b0;
    end

    // directed: empty tree, extremes, saturation, empty ranges, ties
    add_query(0, 1024, 0);
    add_query(2047, 2047, 0);
    add_write(0, 32'sh8000_0000, 0);
    add_write(1023, SENTINEL, 0);
    add_query(0, 1024, 0);
    add_query(1, 1024, 0);
    add_query(1023, 2047, 0);
    add_query(5, 5, 0);
    add_query(1024, 1024, 0);
    add_query(900, 100, 0);
    add_write(1022, VAL_CLAMP, 0);
    add_query(1000, 1024, 0);
    add_write(512, 7, 0);
    add_write(700, 7, 0);
    add_query(1, 1022, 0);
    add_query(1, 512, 0);
    add_write(0, 5, 0);
    add_query(0, 1, 0);
    add_write(341, 32'sh5555_5555, 0);
    add_write(682, 32'shaaaa_aaaa, 0);
    add_query(341, 683, 0);
    add_query(1025, 2046, 0);
    add_query(0, 2047, 0);

    for (int k = 0; k < RANDOM_OPS; k++) begin
      // stretches without idling between stretches with random gaps
      gap = ((k / 150) % 3 == 1) ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 99) < 55) begin
        case ($urandom_range(0, 7))
          0: pos = $urandom_range(0, 15);
          1: pos = $urandom_range(1008, 1023);
          default: pos = $urandom_range(0, 1023);
        endcase
        case ($urandom_range(0, 7))
          0, 1: val = $signed($urandom_range(0, 6)) - 3;
          2: begin
            case ($urandom_range(0, 2))
              0: val = 32'sh8000_0000;
              1: val = SENTINEL;
              default: val = VAL_CLAMP;
            endcase
          end
          default: val = $urandom;
        endcase
        add_write(pos, val, gap);
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            lo = $urandom_range(0, 2047);
            hi = $urandom_range(0, 2047);
          end
          1: begin
            lo = $urandom_range(1, 1024);
            hi = $urandom_range(0, lo);
          end
          2, 3, 4: begin
            lo = $urandom_range(0, 1023);
            hi = lo + $urandom_range(1, 8);
          end
          default: begin
            lo = $urandom_range(0, 1023);
            hi = $urandom_range(lo + 1, 1024);
          end
        endcase
        add_query(lo, hi, gap);
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || start_i || expected_minima.size() != 0)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    if (expected_minima.size() != 0) begin
      $display("%0d expected results never arrived", expected_minima.size());
      errors++;
    end

    $display("covered %0d leaf writes and %0d range queries", n_writes, n_queries);
    $display("queries with a minimum found: %0d, with none found: %0d, mismatches: %0d",
             n_found, n_not_found, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/rmt_pkg.sv
rtl/core/rmt_node_ram.sv
rtl/core/rmt_min_sel.sv
rtl/core/range_min_tree_with_index_core.sv
rtl/core/rmt_checker.sv
verif/range_min_tree_with_index_core_test.sv
